/* hw/rtl/fowc_pkg.sv */
// fowc_pkg: shared types and codes for the order queue with cancel
// operation codes, status codes and the per-cell control struct
// no dependencies
package fowc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W    = 32;
    localparam int DATA_W  = 64;
    localparam int OP_W    = 3;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_EXISTS  = 3'd0,
        OP_ADD     = 3'd1,
        OP_CANCEL  = 3'd2,
        OP_GET     = 3'd3,
        OP_POP     = 3'd4,
        OP_RELEASE = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_IN_USE    = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_BAD_INDEX = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // per-cell command from the queue control
    typedef struct packed {
        logic load;     // take the new order at the tail
        logic set_use;  // mark in use
        logic clr_use;  // clear in use
        logic rm_hit;   // this cell is the one removed
    } cell_ctrl_t;

endpackage

/* hw/rtl/fowc_cell.sv */
// fowc_cell: one queue position holding id, payload and in-use flag
// shifts from its right neighbor when a cell at or left of it is removed
// depends on fowc_pkg
module fowc_cell (
    input  logic                       aclk,
    input  fowc_pkg::cell_ctrl_t       ctrl,
    input  logic [fowc_pkg::ID_W-1:0]  key,
    input  logic [fowc_pkg::DATA_W-1:0] new_data,
    input  logic                       valid,
    input  logic [fowc_pkg::ID_W-1:0]  nb_id,
    input  logic [fowc_pkg::DATA_W-1:0] nb_data,
    input  logic                       nb_use,
    input  logic                       carry_in,
    output logic                       carry_out,
    output logic                       match,
    output logic [fowc_pkg::ID_W-1:0]  id,
    output logic [fowc_pkg::DATA_W-1:0] data,
    output logic                       in_use
);

    logic [fowc_pkg::ID_W-1:0]   id_reg;
    logic [fowc_pkg::DATA_W-1:0] data_reg;
    logic                        use_reg;

    // removal ripples right: every cell from the removed one onward shifts
    assign carry_out = carry_in | ctrl.rm_hit;
    assign match     = valid && (id_reg == key);
    assign id        = id_reg;
    assign data      = data_reg;
    assign in_use    = use_reg;

    always_ff @(posedge aclk) begin
        if (carry_out) begin
            id_reg   <= nb_id;
            data_reg <= nb_data;
            use_reg  <= nb_use;
        end else if (ctrl.load) begin
            id_reg   <= key;
            data_reg <= new_data;
            use_reg  <= 1'b0;
        end else if (ctrl.set_use) begin
            use_reg <= 1'b1;
        end else if (ctrl.clr_use) begin
            use_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/order_fifo_with_cancel.sv */
// order_fifo_with_cancel: order queue with lookup, cancel and get by position
// result: registered in the output stage when the input item is accepted
// throughput: one item per cycle while m_ready is high; each cell compares its id
// and the removal compaction completes in that same cycle across the cell row
// reset clears the entry count and the output valid; cell contents stay undefined
module order_fifo_with_cancel #(
    parameter int QUEUE_DEPTH = fowc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fowc_pkg::OP_W-1:0]     s_op,
    input  logic [fowc_pkg::ID_W-1:0]     s_order_id,
    input  logic [fowc_pkg::DATA_W-1:0]   s_order_data,
    input  logic [fowc_pkg::INDEX_W-1:0]  s_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fowc_pkg::STAT_W-1:0]   m_status,
    output logic                          m_found,
    output logic [fowc_pkg::ID_W-1:0]     m_result_id,
    output logic [fowc_pkg::DATA_W-1:0]   m_result_data
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > fowc_pkg::INDEX_W) ? COUNT_W : fowc_pkg::INDEX_W;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               out_valid_reg;
    logic [fowc_pkg::STAT_W-1:0] status_reg, status_next;
    logic               found_reg, found_next;
    logic [fowc_pkg::ID_W-1:0]   rid_reg, rid_next;
    logic [fowc_pkg::DATA_W-1:0] rdata_reg, rdata_next;

    fowc_pkg::cell_ctrl_t        ctrl    [QUEUE_DEPTH];
    logic [fowc_pkg::ID_W-1:0]   cell_id [QUEUE_DEPTH];
    logic [fowc_pkg::DATA_W-1:0] cell_dat[QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]      cell_use;
    logic [QUEUE_DEPTH-1:0]      cell_valid;
    logic [QUEUE_DEPTH-1:0]      match;
    logic [QUEUE_DEPTH-1:0]      idx_sel;
    logic [QUEUE_DEPTH-1:0]      tail_sel;
    logic [QUEUE_DEPTH:0]        carry;

    logic accept;
    logic any_match, match_use, empty, full, idx_ok;
    logic [QUEUE_DEPTH-1:0] rd_sel;
    logic [fowc_pkg::ID_W-1:0]   rd_id;
    logic [fowc_pkg::DATA_W-1:0] rd_data;
    logic do_add, do_cancel, do_get, do_pop, do_release;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign carry[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [fowc_pkg::ID_W-1:0]   nb_id;
        logic [fowc_pkg::DATA_W-1:0] nb_data;
        logic                        nb_use;

        if (i + 1 < QUEUE_DEPTH) begin : g_nb
            assign nb_id   = cell_id[i+1];
            assign nb_data = cell_dat[i+1];
            assign nb_use  = cell_use[i+1];
        end else begin : g_last
            assign nb_id   = '0;
            assign nb_data = '0;
            assign nb_use  = 1'b0;
        end

        assign cell_valid[i] = COUNT_W'(i) < count_reg;
        assign tail_sel[i]   = COUNT_W'(i) == count_reg;
        assign idx_sel[i]    = CMP_W'(s_index) == CMP_W'(i);

        fowc_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[i]),
            .key       (s_order_id),
            .new_data  (s_order_data),
            .valid     (cell_valid[i]),
            .nb_id     (nb_id),
            .nb_data   (nb_data),
            .nb_use    (nb_use),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .match     (match[i]),
            .id        (cell_id[i]),
            .data      (cell_dat[i]),
            .in_use    (cell_use[i])
        );
    end

    // ids are unique, so at most one cell matches
    assign any_match = |match;
    assign match_use = |(match & cell_use);
    assign empty     = count_reg == '0;
    assign full      = count_reg == COUNT_W'(QUEUE_DEPTH);
    assign idx_ok    = CMP_W'(s_index) < CMP_W'(count_reg);

    always_comb begin
        do_add     = 1'b0;
        do_cancel  = 1'b0;
        do_get     = 1'b0;
        do_pop     = 1'b0;
        do_release = 1'b0;
        status_next = fowc_pkg::ST_OK;
        found_next  = 1'b0;
        unique case (fowc_pkg::op_t'(s_op))
            fowc_pkg::OP_EXISTS: begin
                found_next = any_match;
            end
            fowc_pkg::OP_ADD: begin
                if (any_match) begin
                    status_next = fowc_pkg::ST_NOT_FOUND;
                end else if (full) begin
                    status_next = fowc_pkg::ST_FULL;
                end else begin
                    do_add = 1'b1;
                end
            end
            fowc_pkg::OP_CANCEL: begin
                if (!any_match) begin
                    status_next = fowc_pkg::ST_NOT_FOUND;
                end else if (match_use) begin
                    status_next = fowc_pkg::ST_IN_USE;
                end else begin
                    do_cancel = 1'b1;
                end
            end
            fowc_pkg::OP_GET: begin
                if (empty) begin
                    status_next = fowc_pkg::ST_EMPTY;
                end else if (!idx_ok) begin
                    status_next = fowc_pkg::ST_BAD_INDEX;
                end else begin
                    do_get = 1'b1;
                end
            end
            fowc_pkg::OP_POP: begin
                if (empty) begin
                    status_next = fowc_pkg::ST_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            fowc_pkg::OP_RELEASE: begin
                if (!any_match) begin
                    status_next = fowc_pkg::ST_NOT_FOUND;
                end else begin
                    do_release = 1'b1;
                end
            end
            default: begin
                status_next = fowc_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    assign rd_sel = do_cancel ? match : (do_get ? (idx_sel & cell_valid) : '0);

    always_comb begin
        rd_id   = '0;
        rd_data = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            rd_id   = rd_id   | ({fowc_pkg::ID_W{rd_sel[i]}} & cell_id[i]);
            rd_data = rd_data | ({fowc_pkg::DATA_W{rd_sel[i]}} & cell_dat[i]);
        end
    end

    assign rid_next   = rd_id;
    assign rdata_next = rd_data;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ctrl[i].load    = accept && do_add && tail_sel[i];
            ctrl[i].set_use = accept && do_get && idx_sel[i];
            ctrl[i].clr_use = accept && do_release && match[i];
            ctrl[i].rm_hit  = accept && ((do_cancel && match[i]) || (do_pop && (i == 0)));
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (do_add) begin
                count_next = count_reg + COUNT_W'(1);
            end else if (do_cancel || do_pop) begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rid_reg    <= rid_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_result_id   = rid_reg;
    assign m_result_data = rdata_reg;

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for order_fifo_with_cancel
// runs a directed table, a fill past full, then random order traffic checked against an in-bench queue predictor
// depends on fowc_pkg and the order_fifo_with_cancel rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = fowc_pkg::QUEUE_DEPTH_DEF;
    localparam int N_RANDOM       = 700;
    localparam int N_DIRECTED     = 25;
    localparam int ID_POOL        = 20;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int TAIL_CYCLES    = 8;
    localparam int PEND_DEPTH     = 64;

    localparam logic [fowc_pkg::OP_W-1:0]   OP_RSVD6 = 3'd6;
    localparam logic [fowc_pkg::OP_W-1:0]   OP_RSVD7 = 3'd7;
    localparam logic [fowc_pkg::ID_W-1:0]   ID_MAX   = '1;
    localparam logic [fowc_pkg::DATA_W-1:0] DATA_MAX = '1;

    typedef struct packed {
        fowc_pkg::status_t             status;
        logic                          found;
        logic [fowc_pkg::ID_W-1:0]     rid;
        logic [fowc_pkg::DATA_W-1:0]   rdata;
    } order_rsp_t;

    typedef struct packed {
        logic [fowc_pkg::OP_W-1:0]     op;
        logic [fowc_pkg::ID_W-1:0]     id;
        logic [fowc_pkg::DATA_W-1:0]   data;
        logic [fowc_pkg::INDEX_W-1:0]  idx;
        logic                          pinned;
        order_rsp_t                    rsp;
    } order_row_t;

    localparam order_rsp_t RSP_NONE = '{fowc_pkg::ST_OK, 1'b0, '0, '0};

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [fowc_pkg::OP_W-1:0]      s_op;
    logic [fowc_pkg::ID_W-1:0]      s_order_id;
    logic [fowc_pkg::DATA_W-1:0]    s_order_data;
    logic [fowc_pkg::INDEX_W-1:0]   s_index;
    logic                           m_valid;
    logic                           m_ready;
    logic [fowc_pkg::STAT_W-1:0]    m_status;
    logic                           m_found;
    logic [fowc_pkg::ID_W-1:0]      m_result_id;
    logic [fowc_pkg::DATA_W-1:0]    m_result_data;

    // typed expectation that travels with the item on the input side
    logic                 pin_valid;
    order_rsp_t           pin_rsp;

    logic                 tx_steady = 1'b0;
    logic                 rx_steady = 1'b0;
    logic                 rx_holdoff_req = 1'b0;

    // expected results in order, as a ring with running write and read counts
    order_rsp_t           pend_mem [PEND_DEPTH];
    int                   pend_wr = 0;
    int                   pend_rd = 0;
    int                   sent_count = 0;
    int                   mismatches = 0;

    // queue predictor state
    logic [fowc_pkg::ID_W-1:0]      shadow_id   [DEPTH];
    logic [fowc_pkg::DATA_W-1:0]    shadow_data [DEPTH];
    logic                           shadow_busy [DEPTH];
    int                             shadow_count = 0;

    logic [fowc_pkg::ID_W-1:0]      id_pool [ID_POOL];

    order_row_t dir_rows [N_DIRECTED] = '{
        '{fowc_pkg::OP_EXISTS, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_OK, 1'b0, '0, '0}},
        '{fowc_pkg::OP_POP, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_EMPTY, 1'b0, '0, '0}},
        // empty wins over a bad index
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd15, 1'b1,
          '{fowc_pkg::ST_EMPTY, 1'b0, '0, '0}},
        '{fowc_pkg::OP_CANCEL, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_NOT_FOUND, 1'b0, '0, '0}},
        '{fowc_pkg::OP_RELEASE, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_NOT_FOUND, 1'b0, '0, '0}},
        '{OP_RSVD6, ID_MAX, DATA_MAX, 4'd15, 1'b1,
          '{fowc_pkg::ST_BAD_INDEX, 1'b0, '0, '0}},
        '{OP_RSVD7, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_BAD_INDEX, 1'b0, '0, '0}},
        '{fowc_pkg::OP_ADD, 32'd0, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_OK, 1'b0, '0, '0}},
        '{fowc_pkg::OP_ADD, ID_MAX, DATA_MAX, 4'd0, 1'b1,
          '{fowc_pkg::ST_OK, 1'b0, '0, '0}},
        '{fowc_pkg::OP_ADD, ID_MAX, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_NOT_FOUND, 1'b0, '0, '0}},
        '{fowc_pkg::OP_EXISTS, ID_MAX, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_OK, 1'b1, '0, '0}},
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd1, 1'b1,
          '{fowc_pkg::ST_OK, 1'b0, ID_MAX, DATA_MAX}},
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd2, 1'b1,
          '{fowc_pkg::ST_BAD_INDEX, 1'b0, '0, '0}},
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd15, 1'b1,
          '{fowc_pkg::ST_BAD_INDEX, 1'b0, '0, '0}},
        '{fowc_pkg::OP_CANCEL, ID_MAX, 64'd0, 4'd0, 1'b1,
          '{fowc_pkg::ST_IN_USE, 1'b0, '0, '0}},
        // get of an entry already in use, then releases
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd1, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_RELEASE, ID_MAX, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_RELEASE, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_ADD, 32'h5A5A_A5A5, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0,
          RSP_NONE},
        // cancel from the middle of the queue
        '{fowc_pkg::OP_CANCEL, ID_MAX, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_GET, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE},
        // pop of a head that is in use
        '{fowc_pkg::OP_POP, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_EXISTS, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_POP, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE},
        '{fowc_pkg::OP_POP, 32'd0, 64'd0, 4'd0, 1'b0, RSP_NONE}
    };

    order_fifo_with_cancel i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_order_id    (s_order_id),
        .s_order_data  (s_order_data),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found       (m_found),
        .m_result_id   (m_result_id),
        .m_result_data (m_result_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int find_order(input logic [fowc_pkg::ID_W-1:0] id);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_id[i] == id) return i;
        end
        return -1;
    endfunction

    // remove a cell and close the gap
    function automatic void drop_order(input int pos);
        for (int i = pos; i < shadow_count - 1; i++) begin
            shadow_id[i]   = shadow_id[i+1];
            shadow_data[i] = shadow_data[i+1];
            shadow_busy[i] = shadow_busy[i+1];
        end
        shadow_count--;
    endfunction

    function automatic order_rsp_t apply_order(input logic [fowc_pkg::OP_W-1:0] op,
                                               input logic [fowc_pkg::ID_W-1:0] id,
                                               input logic [fowc_pkg::DATA_W-1:0] data,
                                               input logic [fowc_pkg::INDEX_W-1:0] idx);
        order_rsp_t rsp;
        int pos;
        rsp = RSP_NONE;
        pos = find_order(id);
        case (op)
            fowc_pkg::OP_EXISTS: begin
                rsp.found = (pos >= 0);
            end
            fowc_pkg::OP_ADD: begin
                // duplicate check comes before the full check
                if (pos >= 0) begin
                    rsp.status = fowc_pkg::ST_NOT_FOUND;
                end else if (shadow_count >= DEPTH) begin
                    rsp.status = fowc_pkg::ST_FULL;
                end else begin
                    shadow_id[shadow_count]   = id;
                    shadow_data[shadow_count] = data;
                    shadow_busy[shadow_count] = 1'b0;
                    shadow_count++;
                end
            end
            fowc_pkg::OP_CANCEL: begin
                if (pos < 0) begin
                    rsp.status = fowc_pkg::ST_NOT_FOUND;
                end else if (shadow_busy[pos]) begin
                    rsp.status = fowc_pkg::ST_IN_USE;
                end else begin
                    rsp.rid   = shadow_id[pos];
                    rsp.rdata = shadow_data[pos];
                    drop_order(pos);
                end
            end
            fowc_pkg::OP_GET: begin
                if (shadow_count == 0) begin
                    rsp.status = fowc_pkg::ST_EMPTY;
                end else if (int'(idx) >= shadow_count) begin
                    rsp.status = fowc_pkg::ST_BAD_INDEX;
                end else begin
                    rsp.rid          = shadow_id[idx];
                    rsp.rdata        = shadow_data[idx];
                    shadow_busy[idx] = 1'b1;
                end
            end
            fowc_pkg::OP_POP: begin
                if (shadow_count == 0) rsp.status = fowc_pkg::ST_EMPTY;
                else drop_order(0);
            end
            fowc_pkg::OP_RELEASE: begin
                if (pos < 0) rsp.status = fowc_pkg::ST_NOT_FOUND;
                else shadow_busy[pos] = 1'b0;
            end
            default: begin
                rsp.status = fowc_pkg::ST_BAD_INDEX;
            end
        endcase
        return rsp;
    endfunction

    // predict on input acceptance, compare on result acceptance
    always @(posedge aclk) begin
        order_rsp_t want;
        if (aresetn === 1'b1) begin
            if (s_valid === 1'b1 && s_ready === 1'b1) begin
                want = apply_order(s_op, s_order_id, s_order_data, s_index);
                if (pin_valid) want = pin_rsp;
                pend_mem[pend_wr % PEND_DEPTH] = want;
                pend_wr++;
            end
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (pend_wr == pend_rd) begin
                    $error("result item with nothing pending: status %0d id %h",
                           m_status, m_result_id);
                    mismatches++;
                end else begin
                    want = pend_mem[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, m_found);
                        mismatches++;
                    end
                    if (m_result_id !== want.rid) begin
                        $error("result_id: expected %h, got %h", want.rid, m_result_id);
                        mismatches++;
                    end
                    if (m_result_data !== want.rdata) begin
                        $error("result_data: expected %h, got %h",
                               want.rdata, m_result_data);
                        mismatches++;
                    end
                end
            end
        end
    end

    // result side: random stalls, a steady window and one long hold-off
    initial begin
        logic holdoff_done;
        holdoff_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_holdoff_req && !holdoff_done) begin
                holdoff_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end
            m_ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    task automatic offer_order(input order_row_t row);
        while (!tx_steady && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= row.op;
        s_order_id   <= row.id;
        s_order_data <= row.data;
        s_index      <= row.idx;
        pin_valid    <= row.pinned;
        pin_rsp      <= row.rsp;
        do @(posedge aclk); while (!(s_valid === 1'b1 && s_ready === 1'b1));
        sent_count++;
    endtask

    // every item sent so far has had its result checked
    task automatic wait_drained();
        while (pend_rd < sent_count) @(posedge aclk);
    endtask

    initial begin
        order_row_t row;
        int r;
        logic filling;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = fowc_pkg::OP_EXISTS;
        s_order_id   = '0;
        s_order_data = '0;
        s_index      = '0;
        pin_valid    = 1'b0;
        pin_rsp      = RSP_NONE;
        for (int i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) offer_order(dir_rows[i]);

        // fill to the brim, then one past, then a duplicate while full, then a get of index 15
        row = '{fowc_pkg::OP_ADD, '0, '0, '0, 1'b0, RSP_NONE};
        for (int k = 0; k <= DEPTH; k++) begin
            row.id   = id_pool[k];
            row.data = {$urandom, $urandom};
            offer_order(row);
        end
        row.id = id_pool[0];
        offer_order(row);
        row.op  = fowc_pkg::OP_GET;
        row.idx = 4'd15;
        offer_order(row);

        filling = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) filling = ~filling;
            tx_steady = (n >= 300 && n < 400);
            rx_steady = tx_steady;
            if (n == 150) rx_holdoff_req = 1'b1;
            if (n == 450) wait_drained();

            // refresh the id pool now and then so old ids age out
            if ($urandom_range(99) < 5) id_pool[$urandom_range(ID_POOL-1)] = $urandom;

            r = $urandom_range(99);
            if (r < (filling ? 45 : 20))      row.op = fowc_pkg::OP_ADD;
            else if (r < (filling ? 55 : 30)) row.op = fowc_pkg::OP_EXISTS;
            else if (r < (filling ? 70 : 45)) row.op = fowc_pkg::OP_GET;
            else if (r < (filling ? 80 : 57)) row.op = fowc_pkg::OP_RELEASE;
            else if (r < (filling ? 88 : 75)) row.op = fowc_pkg::OP_CANCEL;
            else if (r < 96)                  row.op = fowc_pkg::OP_POP;
            else row.op = $urandom_range(1) ? OP_RSVD6 : OP_RSVD7;

            row.id   = ($urandom_range(99) < 85) ? id_pool[$urandom_range(ID_POOL-1)]
                                                 : $urandom;
            row.data = {$urandom, $urandom};
            row.idx  = $urandom_range(1) ? 4'($urandom_range(3))
                                         : 4'($urandom_range(15));
            offer_order(row);
        end
        s_valid   <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fowc_pkg.sv
hw/rtl/fowc_cell.sv
hw/rtl/order_fifo_with_cancel.sv
verif/tb.sv
